// ===== design/fresnel_dielectric_reflectance_assert.svh =====
// Assertion macros for the Fresnel reflectance block.
// Depends on clk and rst_n in the scope where a macro is used.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define FDR_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("fdr check failed");

// Check that a condition implies a consequence in the next cycle.
`define FDR_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("fdr check failed");

`endif

// ===== design/fdr_pkg.sv =====
// Shared constants for the Fresnel reflectance pipeline.
// No dependencies.
`default_nettype none
package fdr_pkg;
    localparam int unsigned RATIO_STEPS = 25;
    localparam int unsigned RATIO_LAT = RATIO_STEPS + 2;
    localparam int unsigned K2_STEPS = 31;
    localparam int unsigned SQRT_STEPS = 16;
    localparam logic [1:0] CFG_ETA_INCIDENT = 2'd0;
    localparam logic [1:0] CFG_ETA_TRANSMITTED = 2'd1;
    localparam logic [15:0] ETA_I_RESET = 16'd4096;
    localparam logic [15:0] ETA_T_RESET = 16'd6144;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [48:0] FULL_SQ = 49'h1_0000_0000_0000;
endpackage
`default_nettype wire

// ===== design/fdr_ratio_div.sv =====
// Squared amplitude ratio ((x-y)/(x+y))^2 in Q0.48, one quotient bit per stage.
// Depends on fdr_pkg for the step count and full-scale constant.
`default_nettype none
module fdr_ratio_div (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [31:0] x,
    input  wire logic [31:0] y,
    output logic      [48:0] r_sq
);
    typedef struct packed {
        logic [57:0] rem;
        logic [32:0] sum;
        logic [24:0] q;
        logic        zero;
    } rdiv_t;

    rdiv_t       st_reg [0:fdr_pkg::RATIO_STEPS];
    logic [48:0] r_sq_reg;
    logic [32:0] sum_next;
    logic [31:0] diff_next;

    assign sum_next  = {1'b0, x} + {1'b0, y};
    assign diff_next = (x > y) ? (x - y) : (y - x);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].rem  <= {2'd0, diff_next, 24'd0};
            st_reg[0].sum  <= sum_next;
            st_reg[0].q    <= '0;
            st_reg[0].zero <= (sum_next == 33'd0);
        end
    end

    genvar k;
    generate
        for (k = 0; k < fdr_pkg::RATIO_STEPS; k++)
        begin : g_step
            logic [57:0] dsub;
            logic        take;
            assign dsub = {25'd0, st_reg[k].sum} << (fdr_pkg::RATIO_STEPS - 1 - k);
            assign take = (st_reg[k].rem >= dsub);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[k+1].rem  <= take ? (st_reg[k].rem - dsub) : st_reg[k].rem;
                    st_reg[k+1].sum  <= st_reg[k].sum;
                    st_reg[k+1].q    <= {st_reg[k].q[23:0], take};
                    st_reg[k+1].zero <= st_reg[k].zero;
                end
            end
        end
    endgenerate

    logic [49:0] prod;
    assign prod = {25'd0, st_reg[fdr_pkg::RATIO_STEPS].q}
                * {25'd0, st_reg[fdr_pkg::RATIO_STEPS].q};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_sq_reg <= st_reg[fdr_pkg::RATIO_STEPS].zero ? fdr_pkg::FULL_SQ : prod[48:0];
        end
    end

    assign r_sq = r_sq_reg;
endmodule
`default_nettype wire

// ===== design/fresnel_dielectric_reflectance.sv =====
// Channel     Dir  Fields
// in          in   cos_incident (Q1.15 signed)
// out         out  reflectance (Q0.16), total_internal
// cfg         in   cfg_index, cfg_data (eta registers, Q4.12)
// One transaction per cycle unless the output stalls; each passes from input to
// output through a bit-per-stage divider (31 stages), square root (16 stages) and
// ratio dividers (27 stages).
// Reset clears the valid bits and loads eta 1.0 / 1.5. Any stall at the
// output freezes the whole pipeline; nothing is lost or repeated.
// Top level of the Fresnel reflectance block; depends on fdr_pkg,
// fdr_ratio_div and fresnel_dielectric_reflectance_assert.svh.
`default_nettype none
`include "fresnel_dielectric_reflectance_assert.svh"
module fresnel_dielectric_reflectance (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] cos_incident,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] reflectance,
    output logic             total_internal,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int unsigned P_DIV = 3;
    localparam int unsigned P_SQRT = P_DIV + fdr_pkg::K2_STEPS;
    localparam int unsigned P_MUL = P_SQRT + fdr_pkg::SQRT_STEPS + 1;
    localparam int unsigned P_LAST = P_MUL + fdr_pkg::RATIO_LAT;

    typedef struct packed {
        logic [61:0] rem;
        logic [30:0] q;
        logic [31:0] et2;
        logic [16:0] c;
        logic [15:0] ei;
        logic [15:0] et;
        logic        tir;
    } div_t;

    typedef struct packed {
        logic [30:0] v;
        logic [31:0] root;
        logic [16:0] c;
        logic [15:0] ei;
        logic [15:0] et;
        logic        tir;
    } sqrt_t;

    logic [15:0] eta_i_reg;
    logic [15:0] eta_t_reg;
    logic        adv;
    logic [P_LAST:0] v_reg;
    logic        out_valid_reg;
    logic [15:0] refl_reg;
    logic        tir_out_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_i_reg <= fdr_pkg::ETA_I_RESET;
            eta_t_reg <= fdr_pkg::ETA_T_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fdr_pkg::CFG_ETA_INCIDENT:    eta_i_reg <= cfg_data;
                fdr_pkg::CFG_ETA_TRANSMITTED: eta_t_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[P_LAST-1:0], in_valid};
            out_valid_reg <= v_reg[P_LAST];
        end
    end

    // Stage 0: resolve direction
    logic        enter;
    logic [16:0] c_next;
    logic [16:0] c0_reg;
    logic [15:0] ei0_reg;
    logic [15:0] et0_reg;

    assign enter  = (cos_incident != 16'd0) && !cos_incident[15];
    assign c_next = enter ? {1'b0, cos_incident}
                  : ((cos_incident == 16'd0) ? 17'd0 : (17'h10000 - {1'b0, cos_incident}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg  <= c_next;
            ei0_reg <= enter ? eta_i_reg : eta_t_reg;
            et0_reg <= enter ? eta_t_reg : eta_i_reg;
        end
    end

    // Stage 1: squares
    logic [33:0] csq;
    logic [30:0] s2_1_reg;
    logic [31:0] ei2_1_reg;
    logic [31:0] et2_1_reg;
    logic [16:0] c1_reg;
    logic [15:0] ei1_reg;
    logic [15:0] et1_reg;

    assign csq = c0_reg * c0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_1_reg  <= fdr_pkg::ONE_Q30 - csq[30:0];
            ei2_1_reg <= ei0_reg * ei0_reg;
            et2_1_reg <= et0_reg * et0_reg;
            c1_reg    <= c0_reg;
            ei1_reg   <= ei0_reg;
            et1_reg   <= et0_reg;
        end
    end

    // Stage 2: numerator
    logic [62:0] num2_reg;
    logic [31:0] et2_2_reg;
    logic [16:0] c2_reg;
    logic [15:0] ei2_reg;
    logic [15:0] et2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num2_reg  <= {31'd0, ei2_1_reg} * {32'd0, s2_1_reg};
            et2_2_reg <= et2_1_reg;
            c2_reg    <= c1_reg;
            ei2_reg   <= ei1_reg;
            et2_reg   <= et1_reg;
        end
    end

    // Stage 3: total internal reflection test, then cosine-squared division
    div_t        div_reg [0:fdr_pkg::K2_STEPS];
    logic [61:0] den;
    logic        tir_next;

    assign den      = {et2_2_reg, 30'd0};
    assign tir_next = (num2_reg >= {1'b0, den});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0].rem <= tir_next ? 62'd0 : (den - num2_reg[61:0]);
            div_reg[0].q   <= '0;
            div_reg[0].et2 <= et2_2_reg;
            div_reg[0].c   <= c2_reg;
            div_reg[0].ei  <= ei2_reg;
            div_reg[0].et  <= et2_reg;
            div_reg[0].tir <= tir_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < fdr_pkg::K2_STEPS; k++)
        begin : g_div
            logic [61:0] dsub;
            logic        take;
            assign dsub = {30'd0, div_reg[k].et2} << (fdr_pkg::K2_STEPS - 1 - k);
            assign take = (div_reg[k].rem >= dsub);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_reg[k+1].rem <= take ? (div_reg[k].rem - dsub) : div_reg[k].rem;
                    div_reg[k+1].q   <= {div_reg[k].q[29:0], take};
                    div_reg[k+1].et2 <= div_reg[k].et2;
                    div_reg[k+1].c   <= div_reg[k].c;
                    div_reg[k+1].ei  <= div_reg[k].ei;
                    div_reg[k+1].et  <= div_reg[k].et;
                    div_reg[k+1].tir <= div_reg[k].tir;
                end
            end
        end
    endgenerate

    // Square root, one result bit per stage
    sqrt_t sq_src [0:fdr_pkg::SQRT_STEPS-1];
    sqrt_t sq_reg [1:fdr_pkg::SQRT_STEPS];

    assign sq_src[0] = {div_reg[fdr_pkg::K2_STEPS].q, 32'd0,
                        div_reg[fdr_pkg::K2_STEPS].c,
                        div_reg[fdr_pkg::K2_STEPS].ei,
                        div_reg[fdr_pkg::K2_STEPS].et,
                        div_reg[fdr_pkg::K2_STEPS].tir};

    genvar j;
    generate
        for (j = 0; j < fdr_pkg::SQRT_STEPS; j++)
        begin : g_sqrt
            logic [31:0] bitv;
            logic [31:0] trial;
            logic        take;
            if (j > 0)
            begin : g_src
                assign sq_src[j] = sq_reg[j];
            end
            assign bitv  = 32'h4000_0000 >> (2 * j);
            assign trial = sq_src[j].root + bitv;
            assign take  = ({1'b0, sq_src[j].v} >= trial);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_reg[j+1].v    <= take ? (sq_src[j].v - trial[30:0]) : sq_src[j].v;
                    sq_reg[j+1].root <= take ? ((sq_src[j].root >> 1) + bitv)
                                             : (sq_src[j].root >> 1);
                    sq_reg[j+1].c    <= sq_src[j].c;
                    sq_reg[j+1].ei   <= sq_src[j].ei;
                    sq_reg[j+1].et   <= sq_src[j].et;
                    sq_reg[j+1].tir  <= sq_src[j].tir;
                end
            end
        end
    endgenerate

    // Amplitude products
    sqrt_t       sq_last;
    logic [15:0] ct;
    logic [32:0] x1_full;
    logic [32:0] x2_full;
    logic [31:0] x1_reg;
    logic [31:0] y1_reg;
    logic [31:0] x2_reg;
    logic [31:0] y2_reg;
    logic [fdr_pkg::RATIO_LAT:0] tir_reg;

    assign sq_last = sq_reg[fdr_pkg::SQRT_STEPS];
    assign ct      = sq_last.root[15:0];
    assign x1_full = sq_last.et * sq_last.c;
    assign x2_full = sq_last.ei * sq_last.c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= x1_full[31:0];
            y1_reg  <= sq_last.ei * ct;
            x2_reg  <= x2_full[31:0];
            y2_reg  <= sq_last.et * ct;
            tir_reg <= {tir_reg[fdr_pkg::RATIO_LAT-1:0], sq_last.tir};
        end
    end

    logic [48:0] r1_sq;
    logic [48:0] r2_sq;

    fdr_ratio_div u_par (
        .clk  (clk),
        .adv  (adv),
        .x    (x1_reg),
        .y    (y1_reg),
        .r_sq (r1_sq)
    );

    fdr_ratio_div u_perp (
        .clk  (clk),
        .adv  (adv),
        .x    (x2_reg),
        .y    (y2_reg),
        .r_sq (r2_sq)
    );

    // Output register
    logic [49:0] sq_sum;
    assign sq_sum = {1'b0, r1_sq} + {1'b0, r2_sq};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tir_reg[fdr_pkg::RATIO_LAT])
            begin
                refl_reg <= 16'hFFFF;
            end
            else
            begin
                refl_reg <= sq_sum[49] ? 16'hFFFF : sq_sum[48:33];
            end
            tir_out_reg <= tir_reg[fdr_pkg::RATIO_LAT];
        end
    end

    assign out_valid      = out_valid_reg;
    assign reflectance    = refl_reg;
    assign total_internal = tir_out_reg;

    `FDR_ASSERT_SAME(a_tir_full, out_valid && total_internal, reflectance == 16'hFFFF)
    `FDR_ASSERT_NEXT(a_stall_holds, !adv, $stable(v_reg) && $stable(out_valid_reg))
    `FDR_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_reg[0])
endmodule
`default_nettype wire
